/* src/wfg_pkg.sv */
// ----------------------------------------------------------------------------
// wfg_pkg
// Shared types and constants for the wait-for graph deadlock detector.
// ----------------------------------------------------------------------------
`default_nettype none

package wfg_pkg;

  // default table sizes
  localparam int THREADS_DEF  = 16;
  localparam int HELD_MAX_DEF = 16;

  // resource code meaning "waiting for nothing"
  localparam logic [15:0] NO_WAIT = 16'hFFFF;

  // thread count after reset
  localparam logic [4:0] ACTIVE_RESET = 5'd16;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_SET_WAIT    = 2'd0,
    FUNC_ADD_HELD    = 2'd1,
    FUNC_REMOVE_HELD = 2'd2,
    FUNC_DETECT      = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NOT_FOUND  = 2'd2,
    ST_BAD_THREAD = 2'd3
  } status_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RM_READ,
    S_RM_CMP,
    S_RM_LAST,
    S_RM_MOVE,
    S_SWEEP,
    S_DRAIN,
    S_CLOSE_INIT,
    S_CLOSE,
    S_FINISH
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic    take;
    logic    write_wait;
    logic    add_held;
    logic    rm_next;
    logic    rm_hit;
    logic    rm_move;
    logic    sweep_start;
    logic    sweep_step;
    logic    close_init;
    logic    close_step;
    logic    set_res;
    status_t res_st;
    logic    res_dl;
    logic    finish;
  } wfg_cmd_t;

  // datapath to controller status
  typedef struct packed {
    func_t func;
    logic  bad;
    logic  full;
    logic  empty;
    logic  match;
    logic  col_last;
    logic  sweep_last;
    logic  reach_stable;
    logic  out_free;
  } wfg_stat_t;

endpackage

`default_nettype wire

/* src/wfg_datapath.sv */
// ----------------------------------------------------------------------------
// wfg_datapath
// Wait-for table storage, held-resource memory, adjacency sweep, reachability
// closure and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wfg_datapath #(
  parameter int THREADS  = 16,
  parameter int HELD_MAX = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         func,
  input  logic [3:0]         thread,
  input  logic signed [15:0] user,
  input  logic               cfg_we,
  input  logic [4:0]         active_threads,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               deadlock,
  output logic [1:0]         status,
  input  wfg_pkg::wfg_cmd_t  cmd,
  output wfg_pkg::wfg_stat_t stat
);
  import wfg_pkg::*;

  localparam int ROW_W = $clog2(THREADS);
  localparam int COL_W = $clog2(HELD_MAX);
  localparam int CNT_W = $clog2(HELD_MAX + 1);
  localparam int N_W   = $clog2(THREADS + 1);
  localparam int CMP_W = (N_W > 4) ? N_W : 4;
  localparam int MEM_D = 2 ** (ROW_W + COL_W);

  logic [4:0]             active_q;
  func_t                  func_q;
  logic [3:0]             thread_q;
  logic [15:0]            user_q;
  logic [ROW_W-1:0]       row;
  logic [COL_W-1:0]       col;
  logic [COL_W-1:0]       hit;
  logic [15:0]            wait_target [THREADS];
  logic [CNT_W-1:0]       held_count  [THREADS];
  logic [15:0]            held_mem    [MEM_D];
  logic [15:0]            rdata;
  logic [ROW_W-1:0]       tag_q;
  logic                   tag_valid;
  logic [THREADS-1:0]     adj         [THREADS];
  logic [THREADS-1:0]     reach;
  logic [THREADS-1:0]     reach_next;
  status_t                res_st_q;
  logic                   res_dl_q;

  logic [N_W-1:0]         n_eff;
  logic [CNT_W-1:0]       cur_count;
  logic [CNT_W-1:0]       col_ext;
  logic                   col_last;
  logic                   issue;
  logic                   row_last;
  logic [ROW_W-1:0]       t_row;
  logic                   load;
  logic                   mem_we;
  logic [COL_W-1:0]       mem_wcol;
  logic [15:0]            mem_wdata;

  // effective thread count, clamped to 1..THREADS
  always_comb begin
    if (active_q == 5'd0) begin
      n_eff = N_W'(1);
    end else if (int'(active_q) > THREADS) begin
      n_eff = N_W'(THREADS);
    end else begin
      n_eff = N_W'(active_q);
    end
  end

  // row and column bookkeeping
  assign load      = cmd.take && in_valid;
  assign cur_count = held_count[row];
  assign col_ext   = CNT_W'(col);
  assign col_last  = (col_ext + CNT_W'(1)) == cur_count;
  assign issue     = col_ext < cur_count;
  assign row_last  = (N_W'(row) + N_W'(1)) == n_eff;
  assign t_row     = ROW_W'(thread_q);

  // one step of reachability: add successors of every reached thread
  always_comb begin
    reach_next = reach;
    for (int a = 0; a < THREADS; a++) begin
      if (reach[a]) begin
        reach_next = reach_next | adj[a];
      end
    end
  end

  // status to controller
  always_comb begin
    stat.func         = func_q;
    stat.bad          = CMP_W'(thread_q) >= CMP_W'(n_eff);
    stat.full         = cur_count == CNT_W'(HELD_MAX);
    stat.empty        = cur_count == '0;
    stat.match        = rdata == user_q;
    stat.col_last     = col_last;
    stat.sweep_last   = row_last && (!issue || col_last);
    stat.reach_stable = reach_next == reach;
    stat.out_free     = !out_valid || !out_stall;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_q <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_q <= active_threads;
    end
  end

  // operation latch and table pointers
  always_ff @(posedge clk) begin
    if (load) begin
      func_q   <= func_t'(func);
      thread_q <= thread;
      user_q   <= user;
      row      <= ROW_W'(thread);
      col      <= '0;
    end else if (cmd.sweep_start) begin
      row <= '0;
      col <= '0;
    end else if (cmd.sweep_step) begin
      if (!issue || col_last) begin
        row <= row + ROW_W'(1);
        col <= '0;
      end else begin
        col <= col + COL_W'(1);
      end
    end else if (cmd.rm_next) begin
      col <= col + COL_W'(1);
    end else if (cmd.rm_hit) begin
      hit <= col;
      col <= COL_W'(cur_count - CNT_W'(1));
    end
  end

  // wait targets and held counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREADS; i++) begin
        wait_target[i] <= NO_WAIT;
        held_count[i]  <= '0;
      end
    end else begin
      if (cmd.write_wait) begin
        wait_target[row] <= user_q;
      end
      if (cmd.add_held) begin
        held_count[row] <= cur_count + CNT_W'(1);
      end else if (cmd.rm_move) begin
        held_count[row] <= cur_count - CNT_W'(1);
      end
    end
  end

  // held resource memory, one write and one registered read
  assign mem_we    = cmd.add_held || cmd.rm_move;
  assign mem_wcol  = cmd.add_held ? cur_count[COL_W-1:0] : hit;
  assign mem_wdata = cmd.add_held ? user_q : rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      held_mem[{row, mem_wcol}] <= mem_wdata;
    end
    rdata <= held_mem[{row, col}];
  end

  // sweep read tag, aligned with registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else begin
      tag_valid <= cmd.sweep_step && issue;
    end
  end

  always_ff @(posedge clk) begin
    tag_q <= row;
  end

  // adjacency: thread a points at the holder of what a waits for
  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      for (int a = 0; a < THREADS; a++) begin
        adj[a] <= '0;
      end
    end else if (tag_valid) begin
      for (int a = 0; a < THREADS; a++) begin
        if ((N_W'(a) < n_eff) && (ROW_W'(a) != tag_q) &&
            (wait_target[a] != NO_WAIT) && (wait_target[a] == rdata)) begin
          adj[a][tag_q] <= 1'b1;
        end
      end
    end
  end

  // reached set
  always_ff @(posedge clk) begin
    if (rst) begin
      reach <= '0;
    end else if (cmd.close_init) begin
      reach <= adj[t_row];
    end else if (cmd.close_step) begin
      reach <= reach_next;
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_st_q <= cmd.res_st;
      res_dl_q <= cmd.res_dl && reach[t_row];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      deadlock <= res_dl_q;
      status   <= 2'(res_st_q);
    end
  end

endmodule

`default_nettype wire

/* src/wfg_ctrl.sv */
// ----------------------------------------------------------------------------
// wfg_ctrl
// Sequencer for table updates, held-list removal and deadlock detection.
// ----------------------------------------------------------------------------
`default_nettype none

module wfg_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  wfg_pkg::wfg_stat_t stat,
  output wfg_pkg::wfg_cmd_t  cmd
);
  import wfg_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (stat.bad) begin
          state_next = S_FINISH;
        end else begin
          unique case (stat.func)
            FUNC_SET_WAIT:    state_next = S_FINISH;
            FUNC_ADD_HELD:    state_next = S_FINISH;
            FUNC_REMOVE_HELD: state_next = stat.empty ? S_FINISH : S_RM_READ;
            FUNC_DETECT:      state_next = S_SWEEP;
            default:          state_next = S_FINISH;
          endcase
        end
      end
      S_RM_READ:    state_next = S_RM_CMP;
      S_RM_CMP: begin
        if (stat.match) begin
          state_next = S_RM_LAST;
        end else if (stat.col_last) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_RM_READ;
        end
      end
      S_RM_LAST:    state_next = S_RM_MOVE;
      S_RM_MOVE:    state_next = S_FINISH;
      S_SWEEP: begin
        if (stat.sweep_last) state_next = S_DRAIN;
      end
      S_DRAIN:      state_next = S_CLOSE_INIT;
      S_CLOSE_INIT: state_next = S_CLOSE;
      S_CLOSE: begin
        if (stat.reach_stable) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default:      state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd        = '0;
    cmd.res_st = ST_OK;
    unique case (state)
      S_IDLE: cmd.take = 1'b1;
      S_DECODE: begin
        if (stat.bad) begin
          cmd.set_res = 1'b1;
          cmd.res_st  = ST_BAD_THREAD;
        end else begin
          unique case (stat.func)
            FUNC_SET_WAIT: begin
              cmd.write_wait = 1'b1;
              cmd.set_res    = 1'b1;
            end
            FUNC_ADD_HELD: begin
              cmd.set_res = 1'b1;
              if (stat.full) begin
                cmd.res_st = ST_FULL;
              end else begin
                cmd.add_held = 1'b1;
              end
            end
            FUNC_REMOVE_HELD: begin
              if (stat.empty) begin
                cmd.set_res = 1'b1;
                cmd.res_st  = ST_NOT_FOUND;
              end
            end
            FUNC_DETECT: cmd.sweep_start = 1'b1;
            default: ;
          endcase
        end
      end
      S_RM_READ: ;
      S_RM_CMP: begin
        if (stat.match) begin
          cmd.rm_hit = 1'b1;
        end else if (stat.col_last) begin
          cmd.set_res = 1'b1;
          cmd.res_st  = ST_NOT_FOUND;
        end else begin
          cmd.rm_next = 1'b1;
        end
      end
      S_RM_LAST: ;
      S_RM_MOVE: begin
        cmd.rm_move = 1'b1;
        cmd.set_res = 1'b1;
      end
      S_SWEEP: cmd.sweep_step = 1'b1;
      S_DRAIN: ;
      S_CLOSE_INIT: cmd.close_init = 1'b1;
      S_CLOSE: begin
        cmd.close_step = 1'b1;
        if (stat.reach_stable) begin
          cmd.set_res = 1'b1;
          cmd.res_dl  = 1'b1;
        end
      end
      S_FINISH: cmd.finish = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* src/wait_for_graph_deadlock_detect.sv */
// ----------------------------------------------------------------------------
// wait_for_graph_deadlock_detect
// Wait-for table with held-resource lists and cycle detection.
// ----------------------------------------------------------------------------
// One operation is in flight at a time; the result register lets the next
// operation enter while a result still waits downstream. Remove held reads
// and compares the list entries in turn, and when a match is found the last
// entry is moved into its slot. Detect sweeps the held lists of all active
// threads through the single read port of the held memory, one entry per
// cycle, then closes reachability one hop per cycle. The held memory needs
// no clearing pass after reset.
`default_nettype none

module wait_for_graph_deadlock_detect #(
  parameter int THREADS  = wfg_pkg::THREADS_DEF,
  parameter int HELD_MAX = wfg_pkg::HELD_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [3:0]         thread,
  input  logic signed [15:0] user,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         active_threads,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               deadlock,
  output logic [1:0]         status
);
  import wfg_pkg::*;

  wfg_cmd_t  cmd;
  wfg_stat_t stat;

  // configuration is always taken
  assign cfg_ready = 1'b1;
  assign in_stall  = !cmd.take;

  wfg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  wfg_datapath #(
    .THREADS  (THREADS),
    .HELD_MAX (HELD_MAX)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .func           (func),
    .thread         (thread),
    .user           (user),
    .cfg_we         (cfg_valid && cfg_ready),
    .active_threads (active_threads),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .deadlock       (deadlock),
    .status         (status),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

`default_nettype wire

/* src/wfg_checker.sv */
// ----------------------------------------------------------------------------
// wfg_checker
// Port-level checks for the deadlock detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wfg_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       deadlock,
  input logic [1:0] status
);
  import wfg_pkg::*;

  // one operation at a time: input closes right after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an operation is in flight");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(deadlock)))
    else $error("stalled result changed");

  // a deadlock report only comes with an ok status
  a_deadlock_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && deadlock) |-> (status == 2'(ST_OK)))
    else $error("deadlock flagged with error status");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (!out_valid && !in_stall))
    else $error("block not idle after reset");

endmodule

bind wait_for_graph_deadlock_detect wfg_checker u_wfg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .deadlock  (deadlock),
  .status    (status)
);

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wait-for graph deadlock detector. A clocked
// driver feeds operations from a queue, a shadow wait-for table predicts
// every result, and a clocked monitor compares results in order. The run
// steps through several thread counts and source/sink idling patterns.
// ----------------------------------------------------------------------------
module testbench;
  import wfg_pkg::*;

  localparam int THREADS      = THREADS_DEF;
  localparam int HELD_MAX     = HELD_MAX_DEF;
  localparam int PHASE_ITEMS  = 200;
  localparam int SETTLE       = 16;
  localparam int LIMIT_CYCLES = 6000000;

  typedef enum {IDLE_NONE, IDLE_SRC, IDLE_DST, IDLE_BOTH} idle_mode_t;

  typedef struct {
    func_t       func;
    logic [3:0]  thread;
    logic [15:0] user;
  } lock_op_t;

  typedef struct {
    logic    deadlock;
    status_t status;
  } lock_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         func = 2'd0;
  logic [3:0]         thread = 4'd0;
  logic signed [15:0] user = 16'sd0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [4:0]         active_threads = ACTIVE_RESET;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               deadlock;
  logic [1:0]         status;

  // shadow wait-for table
  logic [15:0]  wait_tgt [THREADS];
  logic [15:0]  held_list [THREADS][HELD_MAX];
  int           held_cnt [THREADS];
  logic [4:0]   thread_cfg;

  lock_op_t     pending_ops[$];
  lock_result_t expected_results[$];
  lock_op_t     cur_op;
  int           src_idle_pct = 0;
  int           dst_stall_pct = 0;
  int           error_count = 0;
  int           cycle_count = 0;
  int           valid_items = 0;

  wait_for_graph_deadlock_detect i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .thread         (thread),
    .user           (user),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .active_threads (active_threads),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .deadlock       (deadlock),
    .status         (status)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // effective thread count, clamped to 1..THREADS
  function automatic int eff_threads();
    int n;
    n = thread_cfg;
    if (n < 1) n = 1;
    if (n > THREADS) n = THREADS;
    return n;
  endfunction

  // threads that hold the resource thread a waits for
  function automatic logic [15:0] next_hops(int a, int n);
    logic [15:0] m;
    int          b;
    int          k;
    m = '0;
    if (wait_tgt[a] != NO_WAIT) begin
      for (b = 0; b < n; b++) begin
        if (b != a) begin
          for (k = 0; k < held_cnt[b]; k++) begin
            if (held_list[b][k] == wait_tgt[a]) m[b] = 1'b1;
          end
        end
      end
    end
    return m;
  endfunction

  // transitive closure of the wait-for edges starting at thread t
  function automatic logic [15:0] reach_from(int t, int n);
    logic [15:0] reach;
    logic [15:0] prev;
    int          a;
    reach = next_hops(t, n);
    do begin
      prev = reach;
      for (a = 0; a < n; a++) begin
        if (reach[a]) reach |= next_hops(a, n);
      end
    end while (reach != prev);
    return reach;
  endfunction

  // update the shadow table for one accepted operation and queue its result
  task automatic apply_op(input lock_op_t op);
    lock_result_t r;
    int           n;
    int           t;
    int           c;
    int           k;
    logic         found;
    logic [15:0]  reach;
    n = eff_threads();
    t = op.thread;
    r.deadlock = 1'b0;
    r.status = ST_OK;
    if (t >= n) begin
      r.status = ST_BAD_THREAD;
    end else begin
      case (op.func)
        FUNC_SET_WAIT: begin
          wait_tgt[t] = op.user;
        end
        FUNC_ADD_HELD: begin
          if (held_cnt[t] >= HELD_MAX) begin
            r.status = ST_FULL;
          end else begin
            held_list[t][held_cnt[t]] = op.user;
            held_cnt[t]++;
          end
        end
        FUNC_REMOVE_HELD: begin
          // first match is replaced by the last entry
          r.status = ST_NOT_FOUND;
          found = 1'b0;
          c = held_cnt[t];
          for (k = 0; k < c; k++) begin
            if (!found && held_list[t][k] == op.user) begin
              held_list[t][k] = held_list[t][c-1];
              held_cnt[t] = c - 1;
              r.status = ST_OK;
              found = 1'b1;
            end
          end
        end
        default: begin
          reach = reach_from(t, n);
          r.deadlock = reach[t];
        end
      endcase
    end
    expected_results.push_back(r);
  endtask

  // input driver: valid never looks at stall, payload held while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_op(cur_op);
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          cur_op = pending_ops.pop_front();
          func <= cur_op.func;
          thread <= cur_op.thread;
          user <= cur_op.user;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < dst_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    lock_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: deadlock %0d status %0d",
               deadlock, status);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (deadlock !== exp_r.deadlock) begin
          $error("deadlock expected %0d actual %0d", exp_r.deadlock, deadlock);
          error_count++;
        end
        if (status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, status);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_op(input func_t f, input int t, input logic [15:0] u);
    lock_op_t op;
    op.func = f;
    op.thread = t[3:0];
    op.user = u;
    pending_ops.push_back(op);
    if (t < eff_threads()) valid_items++;
  endtask

  task automatic set_idle(input idle_mode_t m);
    src_idle_pct = (m == IDLE_SRC) ? 81 : (m == IDLE_BOTH) ? 30 : 0;
    dst_stall_pct = (m == IDLE_DST) ? 81 : (m == IDLE_BOTH) ? 30 : 0;
  endtask

  // wait until every queued operation has its result back
  task automatic drain_results();
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_thread_count(input logic [4:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    active_threads <= v;
    do @(posedge clk); while (!cfg_ready);
    thread_cfg = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_resource();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 16'($urandom_range(0, 7));
    if (roll < 80) return NO_WAIT;
    return 16'($urandom);
  endfunction

  function automatic int pick_thread();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, eff_threads() - 1);
    return $urandom_range(0, THREADS - 1);
  endfunction

  // build a wait-for cycle over k distinct threads, maybe broken, then detect
  task automatic queue_cycle();
    int          n;
    int          k;
    int          i;
    int          j;
    int          tmp;
    int          perm [THREADS];
    logic [15:0] res [THREADS];
    n = eff_threads();
    for (i = 0; i < n; i++) perm[i] = i;
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    k = ($urandom_range(0, 9) == 0) ? n : $urandom_range(2, (n < 6) ? n : 6);
    for (i = 0; i < k; i++) begin
      res[i] = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      queue_op(FUNC_ADD_HELD, perm[i], res[i]);
    end
    for (i = 0; i < k; i++) queue_op(FUNC_SET_WAIT, perm[i], res[(i + 1) % k]);
    // break the cycle now and then
    if ($urandom_range(0, 99) < 30) begin
      if ($urandom_range(0, 1) != 0)
        queue_op(FUNC_SET_WAIT, perm[$urandom_range(0, k - 1)], pick_resource());
      else
        queue_op(FUNC_REMOVE_HELD, perm[$urandom_range(0, k - 1)], res[$urandom_range(0, k - 1)]);
    end
    queue_op(FUNC_DETECT, perm[$urandom_range(0, k - 1)], 16'($urandom));
    // unwind so the lists do not fill up
    if ($urandom_range(0, 1) != 0) begin
      for (i = 0; i < k; i++) begin
        queue_op(FUNC_REMOVE_HELD, perm[i], res[i]);
        if ($urandom_range(0, 1) != 0) queue_op(FUNC_SET_WAIT, perm[i], NO_WAIT);
      end
      queue_op(FUNC_DETECT, perm[$urandom_range(0, k - 1)], 16'($urandom));
    end
  endtask

  // overflow one held list, then empty it again
  task automatic queue_fill();
    int          t;
    int          i;
    logic [15:0] res [HELD_MAX + 1];
    t = $urandom_range(0, eff_threads() - 1);
    for (i = 0; i <= HELD_MAX; i++) begin
      res[i] = pick_resource();
      queue_op(FUNC_ADD_HELD, t, res[i]);
    end
    queue_op(FUNC_DETECT, t, 16'($urandom));
    for (i = HELD_MAX; i >= 0; i--) queue_op(FUNC_REMOVE_HELD, t, res[i]);
  endtask

  task automatic queue_random(input int count);
    int goal;
    int roll;
    goal = valid_items + count;
    while (valid_items < goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 35 && eff_threads() >= 2) begin
        queue_cycle();
      end else if (roll < 38) begin
        queue_fill();
      end else begin
        queue_op(func_t'($urandom_range(0, 3)), pick_thread(), pick_resource());
      end
    end
  endtask

  // directed checks at the reset thread count
  task automatic queue_directed();
    queue_op(FUNC_DETECT, 0, 16'h0000);
    // two-thread cycle
    queue_op(FUNC_ADD_HELD, 1, 16'h0005);
    queue_op(FUNC_SET_WAIT, 0, 16'h0005);
    queue_op(FUNC_ADD_HELD, 0, 16'h0006);
    queue_op(FUNC_SET_WAIT, 1, 16'h0006);
    queue_op(FUNC_DETECT, 0, 16'h0000);
    queue_op(FUNC_DETECT, 1, 16'hFFFF);
    // clearing a wait breaks it
    queue_op(FUNC_SET_WAIT, 0, NO_WAIT);
    queue_op(FUNC_DETECT, 1, 16'h0000);
    // held -1 never matches a cleared wait
    queue_op(FUNC_ADD_HELD, 2, NO_WAIT);
    queue_op(FUNC_SET_WAIT, 3, NO_WAIT);
    queue_op(FUNC_DETECT, 3, 16'h0000);
    // waiting on a resource held by itself is no edge
    queue_op(FUNC_ADD_HELD, 4, 16'h0007);
    queue_op(FUNC_SET_WAIT, 4, 16'h0007);
    queue_op(FUNC_DETECT, 4, 16'h0000);
    // remove of an absent and a present resource
    queue_op(FUNC_REMOVE_HELD, 1, 16'h0009);
    queue_op(FUNC_REMOVE_HELD, 1, 16'h0005);
    // cycle between the top threads with extreme resource codes
    queue_op(FUNC_ADD_HELD, 15, 16'h7FFF);
    queue_op(FUNC_SET_WAIT, 14, 16'h7FFF);
    queue_op(FUNC_ADD_HELD, 14, 16'h8000);
    queue_op(FUNC_SET_WAIT, 15, 16'h8000);
    queue_op(FUNC_DETECT, 15, 16'hFFFF);
  endtask

  // stimulus sequencer
  initial begin
    int          p;
    logic [4:0]  phase_cfg [8];
    phase_cfg = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd2, 5'd9};
    for (p = 0; p < THREADS; p++) begin
      wait_tgt[p] = NO_WAIT;
      held_cnt[p] = 0;
    end
    thread_cfg = ACTIVE_RESET;
    set_idle(IDLE_NONE);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    queue_directed();
    drain_results();

    for (p = 0; p < 8; p++) begin
      write_thread_count(phase_cfg[p]);
      set_idle(idle_mode_t'(p % 4));
      queue_random(PHASE_ITEMS);
      drain_results();
    end

    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
